// ===== hw/rtl/pld_pkg.sv =====
// ----------------------------------------------------------------------------
// pld_pkg
// Shared constants for the point to segment distance and foot point block.
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

    localparam int PLD_COORD_BITS = 32;

    // cycles from the accepting edge to the edge that takes the result
    function automatic int pld_latency(input int coord_bits);
        return 4 * coord_bits + 18;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/point_line_distance_foot.sv =====
// ----------------------------------------------------------------------------
// point_line_distance_foot
// Perpendicular distance of a point to a segment and the foot point, fully
// pipelined fixed point with bit-per-stage square roots and dividers.
// ----------------------------------------------------------------------------
// datapath: two square root and two divider chains in series, one result bit per stage
// throughput: one request per cycle, busy is high only in reset, receiver cannot stall
// reset: synchronous active-low reset clears every valid bit; data is not reset
`default_nettype none

module point_line_distance_foot import pld_pkg::*; #(
    parameter int COORD_BITS = PLD_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_valid,
    output logic        [COORD_BITS+1:0] o_distance,
    output logic signed [COORD_BITS-1:0] o_foot_x,
    output logic signed [COORD_BITS-1:0] o_foot_y,
    output logic                         o_degenerate,
    output logic                         o_overflow
);

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;     // difference, root and quotient width
    localparam int SW = 2 * DW;     // square and product width
    localparam int RW = DW;         // square root steps
    localparam int EW = CW + 3;     // foot sum before saturation

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic        [DW-1:0] mx;
        logic        [DW-1:0] my;
        logic                 nx;
        logic                 ny;
        logic                 degen;
    } t_geo;

    // ---------------- front: deltas, products, sums ----------------
    logic [3:0]           r_pv;
    logic signed [CW-1:0] r_p1_c [0:5];
    logic signed [DW-1:0] r_p2_d [0:5];
    t_geo                 r_p2_g;
    logic signed [SW-1:0] r_p3_sq [0:5];
    logic signed [SW-1:0] r_p3_c1, r_p3_c2;
    t_geo                 r_p3_g;
    t_geo                 n_p3_g;
    logic        [SW-1:0] r_p4_rad [0:2];
    logic signed [SW:0]   r_p4_cr;
    t_geo                 r_p4_g;
    logic        [SW:0]   cr_abs;

    assign busy = !i_rst_n;

    always_comb begin
        n_p3_g       = r_p2_g;
        n_p3_g.mx    = r_p2_d[4][DW-1] ? $unsigned(-r_p2_d[4]) : $unsigned(r_p2_d[4]);
        n_p3_g.my    = r_p2_d[5][DW-1] ? $unsigned(-r_p2_d[5]) : $unsigned(r_p2_d[5]);
        n_p3_g.nx    = r_p2_d[4][DW-1];
        n_p3_g.ny    = r_p2_d[5][DW-1];
        n_p3_g.degen = (r_p2_d[4] == '0) && (r_p2_d[5] == '0);
    end

    always_ff @(posedge i_clk) begin
        r_p1_c[0] <= i_seg_start_x;
        r_p1_c[1] <= i_seg_start_y;
        r_p1_c[2] <= i_seg_end_x;
        r_p1_c[3] <= i_seg_end_y;
        r_p1_c[4] <= i_point_x;
        r_p1_c[5] <= i_point_y;

        // order: dx0 dy0 (point-start), dx1 dy1 (point-end), dx2 dy2 (end-start)
        r_p2_d[0] <= {r_p1_c[4][CW-1], r_p1_c[4]} - {r_p1_c[0][CW-1], r_p1_c[0]};
        r_p2_d[1] <= {r_p1_c[5][CW-1], r_p1_c[5]} - {r_p1_c[1][CW-1], r_p1_c[1]};
        r_p2_d[2] <= {r_p1_c[4][CW-1], r_p1_c[4]} - {r_p1_c[2][CW-1], r_p1_c[2]};
        r_p2_d[3] <= {r_p1_c[5][CW-1], r_p1_c[5]} - {r_p1_c[3][CW-1], r_p1_c[3]};
        r_p2_d[4] <= {r_p1_c[2][CW-1], r_p1_c[2]} - {r_p1_c[0][CW-1], r_p1_c[0]};
        r_p2_d[5] <= {r_p1_c[3][CW-1], r_p1_c[3]} - {r_p1_c[1][CW-1], r_p1_c[1]};
        r_p2_g.sx    <= r_p1_c[0];
        r_p2_g.sy    <= r_p1_c[1];
        r_p2_g.ex    <= r_p1_c[2];
        r_p2_g.ey    <= r_p1_c[3];
        r_p2_g.mx    <= '0;
        r_p2_g.my    <= '0;
        r_p2_g.nx    <= 1'b0;
        r_p2_g.ny    <= 1'b0;
        r_p2_g.degen <= 1'b0;

        for (int i = 0; i < 6; i++) begin
            r_p3_sq[i] <= r_p2_d[i] * r_p2_d[i];
        end
        r_p3_c1 <= r_p2_d[2] * r_p2_d[1];
        r_p3_c2 <= r_p2_d[3] * r_p2_d[0];
        r_p3_g  <= n_p3_g;

        // radicands: b, c, a
        r_p4_rad[0] <= $unsigned(r_p3_sq[0]) + $unsigned(r_p3_sq[1]);
        r_p4_rad[1] <= $unsigned(r_p3_sq[2]) + $unsigned(r_p3_sq[3]);
        r_p4_rad[2] <= $unsigned(r_p3_sq[4]) + $unsigned(r_p3_sq[5]);
        r_p4_cr     <= {r_p3_c1[SW-1], r_p3_c1} - {r_p3_c2[SW-1], r_p3_c2};
        r_p4_g      <= r_p3_g;
    end

    assign cr_abs = r_p4_cr[SW] ? $unsigned(-r_p4_cr) : $unsigned(r_p4_cr);

    // ---------------- square roots of b, c, a ----------------
    logic [RW+1:0] r_sa_rem  [0:RW][0:2];
    logic [RW-1:0] r_sa_root [0:RW][0:2];
    logic [SW-1:0] r_sa_rad  [0:RW][0:2];
    t_geo          r_sa_g    [0:RW];
    logic [SW-1:0] r_sa_cr   [0:RW];
    logic [RW:0]   r_sa_v;
    logic [RW+1:0] sa_shf    [1:RW][0:2];
    logic [RW+1:0] sa_try    [1:RW][0:2];

    always_comb begin
        for (int k = 1; k <= RW; k++) begin
            for (int j = 0; j < 3; j++) begin
                sa_shf[k][j] = {r_sa_rem[k-1][j][RW-1:0], r_sa_rad[k-1][j][SW-1:SW-2]};
                sa_try[k][j] = {r_sa_root[k-1][j], 2'b01};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_sa_rem[0][j]  <= '0;
            r_sa_root[0][j] <= '0;
            r_sa_rad[0][j]  <= r_p4_rad[j];
        end
        r_sa_g[0]  <= r_p4_g;
        r_sa_cr[0] <= cr_abs[SW-1:0];
        for (int k = 1; k <= RW; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_sa_rad[k][j] <= r_sa_rad[k-1][j] << 2;
                if (sa_shf[k][j] >= sa_try[k][j]) begin
                    r_sa_rem[k][j]  <= sa_shf[k][j] - sa_try[k][j];
                    r_sa_root[k][j] <= {r_sa_root[k-1][j][RW-2:0], 1'b1};
                end else begin
                    r_sa_rem[k][j]  <= sa_shf[k][j];
                    r_sa_root[k][j] <= {r_sa_root[k-1][j][RW-2:0], 1'b0};
                end
            end
            r_sa_g[k]  <= r_sa_g[k-1];
            r_sa_cr[k] <= r_sa_cr[k-1];
        end
    end

    // ---------------- |cross| / a ----------------
    logic [DW:0]   r_db_rem [0:DW];
    logic [DW-1:0] r_db_num [0:DW];
    logic [DW-1:0] r_db_q   [0:DW];
    logic [DW-1:0] r_db_a   [0:DW];
    logic [DW-1:0] r_db_b   [0:DW];
    logic [DW-1:0] r_db_c   [0:DW];
    t_geo          r_db_g   [0:DW];
    logic [DW:0]   r_db_big;
    logic [DW:0]   r_db_v;
    logic [DW:0]   db_shf   [1:DW];

    always_comb begin
        for (int k = 1; k <= DW; k++) begin
            db_shf[k] = {r_db_rem[k-1][DW-1:0], r_db_num[k-1][DW-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        // quotient at or above 2^DW exceeds b, so only the low part is divided
        r_db_rem[0] <= {1'b0, r_sa_cr[RW][SW-1:DW]};
        r_db_num[0] <= r_sa_cr[RW][DW-1:0];
        r_db_q[0]   <= '0;
        r_db_big[0] <= r_sa_cr[RW][SW-1:DW] >= r_sa_root[RW][2];
        r_db_a[0]   <= r_sa_root[RW][2];
        r_db_b[0]   <= r_sa_root[RW][0];
        r_db_c[0]   <= r_sa_root[RW][1];
        r_db_g[0]   <= r_sa_g[RW];
        for (int k = 1; k <= DW; k++) begin
            r_db_num[k] <= r_db_num[k-1] << 1;
            if (db_shf[k] >= {1'b0, r_db_a[k-1]}) begin
                r_db_rem[k] <= db_shf[k] - {1'b0, r_db_a[k-1]};
                r_db_q[k]   <= {r_db_q[k-1][DW-2:0], 1'b1};
            end else begin
                r_db_rem[k] <= db_shf[k];
                r_db_q[k]   <= {r_db_q[k-1][DW-2:0], 1'b0};
            end
            r_db_big[k] <= r_db_big[k-1];
            r_db_a[k]   <= r_db_a[k-1];
            r_db_b[k]   <= r_db_b[k-1];
            r_db_c[k]   <= r_db_c[k-1];
            r_db_g[k]   <= r_db_g[k-1];
        end
    end

    // ---------------- clamp h, squares ----------------
    logic [1:0]    r_cv;
    logic [DW-1:0] r_c0_h, r_c0_a, r_c0_b, r_c0_c;
    t_geo          r_c0_g;
    logic [SW-1:0] r_c1_bb, r_c1_cc, r_c1_hh;
    logic [DW-1:0] r_c1_h, r_c1_a;
    t_geo          r_c1_g;
    logic [DW-1:0] hq, hb, hc;

    always_comb begin
        hq = r_db_big[DW] ? r_db_b[DW] : r_db_q[DW];
        hb = (hq > r_db_b[DW]) ? r_db_b[DW] : hq;
        hc = (hb > r_db_c[DW]) ? r_db_c[DW] : hb;
    end

    always_ff @(posedge i_clk) begin
        r_c0_h  <= r_db_g[DW].degen ? r_db_b[DW] : hc;
        r_c0_a  <= r_db_a[DW];
        r_c0_b  <= r_db_b[DW];
        r_c0_c  <= r_db_c[DW];
        r_c0_g  <= r_db_g[DW];
        r_c1_bb <= r_c0_b * r_c0_b;
        r_c1_cc <= r_c0_c * r_c0_c;
        r_c1_hh <= r_c0_h * r_c0_h;
        r_c1_h  <= r_c0_h;
        r_c1_a  <= r_c0_a;
        r_c1_g  <= r_c0_g;
    end

    // ---------------- square roots l0, l1 ----------------
    logic [RW+1:0] r_sc_rem  [0:RW][0:1];
    logic [RW-1:0] r_sc_root [0:RW][0:1];
    logic [SW-1:0] r_sc_rad  [0:RW][0:1];
    logic [DW-1:0] r_sc_h    [0:RW];
    logic [DW-1:0] r_sc_a    [0:RW];
    t_geo          r_sc_g    [0:RW];
    logic [RW:0]   r_sc_v;
    logic [RW+1:0] sc_shf    [1:RW][0:1];
    logic [RW+1:0] sc_try    [1:RW][0:1];

    always_comb begin
        for (int k = 1; k <= RW; k++) begin
            for (int j = 0; j < 2; j++) begin
                sc_shf[k][j] = {r_sc_rem[k-1][j][RW-1:0], r_sc_rad[k-1][j][SW-1:SW-2]};
                sc_try[k][j] = {r_sc_root[k-1][j], 2'b01};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            r_sc_rem[0][j]  <= '0;
            r_sc_root[0][j] <= '0;
        end
        r_sc_rad[0][0] <= r_c1_bb - r_c1_hh;
        r_sc_rad[0][1] <= r_c1_cc - r_c1_hh;
        r_sc_h[0]      <= r_c1_h;
        r_sc_a[0]      <= r_c1_a;
        r_sc_g[0]      <= r_c1_g;
        for (int k = 1; k <= RW; k++) begin
            for (int j = 0; j < 2; j++) begin
                r_sc_rad[k][j] <= r_sc_rad[k-1][j] << 2;
                if (sc_shf[k][j] >= sc_try[k][j]) begin
                    r_sc_rem[k][j]  <= sc_shf[k][j] - sc_try[k][j];
                    r_sc_root[k][j] <= {r_sc_root[k-1][j][RW-2:0], 1'b1};
                end else begin
                    r_sc_rem[k][j]  <= sc_shf[k][j];
                    r_sc_root[k][j] <= {r_sc_root[k-1][j][RW-2:0], 1'b0};
                end
            end
            r_sc_h[k] <= r_sc_h[k-1];
            r_sc_a[k] <= r_sc_a[k-1];
            r_sc_g[k] <= r_sc_g[k-1];
        end
    end

    // ---------------- pick end, scale direction ----------------
    logic [1:0]    r_dv;
    logic [DW-1:0] r_d0_l, r_d0_h, r_d0_a;
    logic          r_d0_fe;
    t_geo          r_d0_g;
    logic [SW-1:0] r_d1_nx, r_d1_ny;
    logic [DW-1:0] r_d1_h, r_d1_a;
    logic          r_d1_fe;
    t_geo          r_d1_g;
    logic          from_end;
    logic [DW-1:0] l0, l1;

    always_comb begin
        l0 = r_sc_root[RW][0];
        l1 = r_sc_root[RW][1];
        // point beyond the segment and closer to the start
        from_end = ((l0 > r_sc_a[RW]) || (l1 > r_sc_a[RW])) && !(l0 > l1);
    end

    always_ff @(posedge i_clk) begin
        r_d0_l  <= from_end ? l1 : l0;
        r_d0_fe <= from_end;
        r_d0_h  <= r_sc_h[RW];
        r_d0_a  <= r_sc_a[RW];
        r_d0_g  <= r_sc_g[RW];
        r_d1_nx <= r_d0_g.mx * r_d0_l;
        r_d1_ny <= r_d0_g.my * r_d0_l;
        r_d1_fe <= r_d0_fe;
        r_d1_h  <= r_d0_h;
        r_d1_a  <= r_d0_a;
        r_d1_g  <= r_d0_g;
    end

    // ---------------- offsets divided by a ----------------
    logic [DW:0]   r_dd_rem [0:DW][0:1];
    logic [DW-1:0] r_dd_num [0:DW][0:1];
    logic [DW-1:0] r_dd_q   [0:DW][0:1];
    logic [DW-1:0] r_dd_a   [0:DW];
    logic [DW-1:0] r_dd_h   [0:DW];
    logic [DW:0]   r_dd_fe;
    t_geo          r_dd_g   [0:DW];
    logic [DW:0]   r_dd_v;
    logic [DW:0]   dd_shf   [1:DW][0:1];

    always_comb begin
        for (int k = 1; k <= DW; k++) begin
            for (int j = 0; j < 2; j++) begin
                dd_shf[k][j] = {r_dd_rem[k-1][j][DW-1:0], r_dd_num[k-1][j][DW-1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // offset never exceeds l, so the high part is already below a
        r_dd_rem[0][0] <= {1'b0, r_d1_nx[SW-1:DW]};
        r_dd_rem[0][1] <= {1'b0, r_d1_ny[SW-1:DW]};
        r_dd_num[0][0] <= r_d1_nx[DW-1:0];
        r_dd_num[0][1] <= r_d1_ny[DW-1:0];
        r_dd_q[0][0]   <= '0;
        r_dd_q[0][1]   <= '0;
        r_dd_a[0]      <= r_d1_a;
        r_dd_h[0]      <= r_d1_h;
        r_dd_fe[0]     <= r_d1_fe;
        r_dd_g[0]      <= r_d1_g;
        for (int k = 1; k <= DW; k++) begin
            for (int j = 0; j < 2; j++) begin
                r_dd_num[k][j] <= r_dd_num[k-1][j] << 1;
                if (dd_shf[k][j] >= {1'b0, r_dd_a[k-1]}) begin
                    r_dd_rem[k][j] <= dd_shf[k][j] - {1'b0, r_dd_a[k-1]};
                    r_dd_q[k][j]   <= {r_dd_q[k-1][j][DW-2:0], 1'b1};
                end else begin
                    r_dd_rem[k][j] <= dd_shf[k][j];
                    r_dd_q[k][j]   <= {r_dd_q[k-1][j][DW-2:0], 1'b0};
                end
            end
            r_dd_a[k]  <= r_dd_a[k-1];
            r_dd_h[k]  <= r_dd_h[k-1];
            r_dd_fe[k] <= r_dd_fe[k-1];
            r_dd_g[k]  <= r_dd_g[k-1];
        end
    end

    // ---------------- place foot, saturate ----------------
    logic                 r_ev;
    logic signed [EW-1:0] r_e_fx, r_e_fy;
    logic        [DW-1:0] r_e_h;
    logic signed [CW-1:0] r_e_sx, r_e_sy;
    logic                 r_e_degen;
    logic                 r_o_v;
    logic        [CW+1:0] r_o_dist;
    logic signed [CW-1:0] r_o_fx, r_o_fy;
    logic                 r_o_degen, r_o_ovf;

    logic signed [CW-1:0] base_x, base_y;
    logic                 neg_x, neg_y;
    logic signed [EW-1:0] off_x, off_y;
    logic signed [CW-1:0] sat_x, sat_y;
    logic                 ovf_x, ovf_y;

    always_comb begin
        base_x = r_dd_fe[DW] ? r_dd_g[DW].ex : r_dd_g[DW].sx;
        base_y = r_dd_fe[DW] ? r_dd_g[DW].ey : r_dd_g[DW].sy;
        // going back from the end flips the direction sign
        neg_x  = r_dd_fe[DW] ? !r_dd_g[DW].nx : r_dd_g[DW].nx;
        neg_y  = r_dd_fe[DW] ? !r_dd_g[DW].ny : r_dd_g[DW].ny;
        off_x  = $signed({2'b00, r_dd_q[DW][0]});
        off_y  = $signed({2'b00, r_dd_q[DW][1]});

        ovf_x = (r_e_fx[EW-1:CW-1] != '0) && (r_e_fx[EW-1:CW-1] != '1);
        ovf_y = (r_e_fy[EW-1:CW-1] != '0) && (r_e_fy[EW-1:CW-1] != '1);
        if (ovf_x) begin
            sat_x = r_e_fx[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            sat_x = r_e_fx[CW-1:0];
        end
        if (ovf_y) begin
            sat_y = r_e_fy[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            sat_y = r_e_fy[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_fx    <= neg_x ? EW'(base_x) - off_x : EW'(base_x) + off_x;
        r_e_fy    <= neg_y ? EW'(base_y) - off_y : EW'(base_y) + off_y;
        r_e_h     <= r_dd_h[DW];
        r_e_sx    <= r_dd_g[DW].sx;
        r_e_sy    <= r_dd_g[DW].sy;
        r_e_degen <= r_dd_g[DW].degen;

        r_o_dist  <= {1'b0, r_e_h};
        r_o_degen <= r_e_degen;
        if (r_e_degen) begin
            r_o_fx  <= r_e_sx;
            r_o_fy  <= r_e_sy;
            r_o_ovf <= 1'b0;
        end else begin
            r_o_fx  <= sat_x;
            r_o_fy  <= sat_y;
            r_o_ovf <= ovf_x || ovf_y;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= '0;
            r_sa_v <= '0;
            r_db_v <= '0;
            r_cv   <= '0;
            r_sc_v <= '0;
            r_dv   <= '0;
            r_dd_v <= '0;
            r_ev   <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            r_pv   <= {r_pv[2:0], start && !busy};
            r_sa_v <= {r_sa_v[RW-1:0], r_pv[3]};
            r_db_v <= {r_db_v[DW-1:0], r_sa_v[RW]};
            r_cv   <= {r_cv[0], r_db_v[DW]};
            r_sc_v <= {r_sc_v[RW-1:0], r_cv[1]};
            r_dv   <= {r_dv[0], r_sc_v[RW]};
            r_dd_v <= {r_dd_v[DW-1:0], r_dv[1]};
            r_ev   <= r_dd_v[DW];
            r_o_v  <= r_ev;
        end
    end

    assign o_valid      = r_o_v;
    assign o_distance   = r_o_dist;
    assign o_foot_x     = r_o_fx;
    assign o_foot_y     = r_o_fy;
    assign o_degenerate = r_o_degen;
    assign o_overflow   = r_o_ovf;

endmodule

`default_nettype wire

// ===== hw/rtl/pld_checker.sv =====
// ----------------------------------------------------------------------------
// pld_checker
// Port level checks for point_line_distance_foot, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_checker import pld_pkg::*; #(
    parameter int COORD_BITS = PLD_COORD_BITS
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic signed [COORD_BITS-1:0] i_seg_start_x,
    input wire logic signed [COORD_BITS-1:0] i_seg_start_y,
    input wire logic signed [COORD_BITS-1:0] i_seg_end_x,
    input wire logic signed [COORD_BITS-1:0] i_seg_end_y,
    input wire logic signed [COORD_BITS-1:0] i_point_x,
    input wire logic signed [COORD_BITS-1:0] i_point_y,
    input wire logic                         o_valid,
    input wire logic        [COORD_BITS+1:0] o_distance,
    input wire logic signed [COORD_BITS-1:0] o_foot_x,
    input wire logic signed [COORD_BITS-1:0] o_foot_y,
    input wire logic                         o_degenerate,
    input wire logic                         o_overflow
);

    localparam int LAT = pld_latency(COORD_BITS);
    localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

    // every request comes out after the fixed latency
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("request did not produce a result");

    // no result without a request
    a_result_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without request");

    // zero-length segment returns the start point
    a_degen_foot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> !o_overflow
            && o_foot_x == $past(i_seg_start_x, LAT)
            && o_foot_y == $past(i_seg_start_y, LAT))
        else $error("degenerate result wrong");

    // overflow only with a saturated foot coordinate
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_foot_x == MAXV || o_foot_x == MINV
            || o_foot_y == MAXV || o_foot_y == MINV)
        else $error("overflow without saturation");

endmodule

bind point_line_distance_foot pld_checker #(.COORD_BITS(COORD_BITS)) u_pld_checker (.*);

`default_nettype wire
